// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AES_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/aes_pkg.sv =====
// Shared types, constants, S-box tables and round functions for the AES core.
// No dependencies; used by aes_key_expand, aes_round and aes_block_cipher.
package aes_pkg;

    localparam int RK_DEPTH_DEF = 60;
    localparam int MAX_ROUNDS = 14;
    localparam int BLOCK_W = 128;
    localparam int RK_COUNT_W = $clog2(4 * (MAX_ROUNDS + 1));

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;
    localparam logic [1:0] MODE_256_ALIAS = 2'd3;

    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_KEY0 = 3'd1;
    localparam logic [2:0] CFG_KEY1 = 3'd2;
    localparam logic [2:0] CFG_KEY2 = 3'd3;
    localparam logic [2:0] CFG_KEY3 = 3'd4;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY = 8'h1B;

    typedef logic [7:0] sbox_t [256];

    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic [BLOCK_W-1:0]   state;
    } stage_t;

    localparam sbox_t SBOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic sbox_t inv_gen();
        sbox_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam sbox_t INV_SBOX = inv_gen();

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [3:0] rounds_of_mode(input logic [1:0] mode);
        logic [3:0] nr;
        case (mode)
            MODE_128: nr = 4'd10;
            MODE_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
        return nr;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [BLOCK_W-1:0] subst_state(input logic [BLOCK_W-1:0] s,
                                                       input logic inv);
        logic [BLOCK_W-1:0] t;
        for (int n = 0; n < 16; n++)
        begin
            t[8*n +: 8] = inv ? INV_SBOX[s[8*n +: 8]] : SBOX[s[8*n +: 8]];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] rotate_state_rows(input logic [BLOCK_W-1:0] s,
                                                             input logic inv);
        logic [BLOCK_W-1:0] t;
        int src;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? 4 * ((c - r + 4) & 3) + r : 4 * ((c + r) & 3) + r;
                t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * src -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++)
        begin
            a[k]  = col[31 - 8 * k -: 8];
            x2[k] = xt(a[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
        end
        for (int r = 0; r < 4; r++)
        begin
            if (inv)
            begin
                o[31 - 8 * r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3])
                    ^ (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3])
                    ^ (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
            end
            else
            begin
                o[31 - 8 * r -: 8] = x2[r] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3]
                    ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
            end
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_state(input logic [BLOCK_W-1:0] s,
                                                     input logic inv);
        logic [BLOCK_W-1:0] t;
        for (int c = 0; c < 4; c++)
        begin
            t[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
        end
        return t;
    endfunction

endpackage

// ===== rtl/aes_block_cipher.sv =====
// AES block cipher top level: configuration registers, key expansion and pipeline.
// Depends on aes_pkg, aes_key_expand, aes_round and assert_macros.svh.
//
// Usage:
//   Write key_size_mode and the key parts over the cfg channel (index 0 to 4).
//   Each accepted write to index 0 to 4 starts a round key expansion: a start
//   register, a load state, then a run state that derives the remaining key words.
//   cfg_ready and s_axis_tready stay low while the expansion runs.
//   Blocks enter on the s_axis channel, the flag in tuser selecting decrypt.
//   The datapath is a 15 stage pipeline: the initial key addition and one
//   stage for each of up to 14 rounds; every block passes through all stages
//   whatever the key size, and shorter keys bypass the later round logic.
//   Throughput is one block per cycle, one round unit per stage, while not stalled or busy.
//   A stall on m_axis_tready holds the whole pipeline; nothing is lost.
//   Reset clears the pipeline valid bits and the configuration to zero;
//   the round key store holds no meaningful data until a key is written.
module aes_block_cipher #(
    parameter int RK_DEPTH = aes_pkg::RK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // data_hi[63:0], data_lo[127:64]
    input  logic [0:0]    s_axis_tuser,   // operation[0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // result_hi[63:0], result_lo[127:64]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    localparam int NS = aes_pkg::MAX_ROUNDS;

    logic [1:0]                        mode_reg;
    logic [3:0][63:0]                  key_reg;
    logic                              start_reg;
    logic                              key_busy;
    logic                              busy;
    logic                              advance;
    logic                              cfg_fire;
    logic [NS:0][aes_pkg::BLOCK_W-1:0] rkey;
    logic [aes_pkg::BLOCK_W-1:0]       first_key;
    logic [aes_pkg::BLOCK_W-1:0]       in_state;
    aes_pkg::stage_t                   pipe [NS+1];
    logic                              v0_reg;
    logic                              op0_reg;
    logic [aes_pkg::BLOCK_W-1:0]       st0_reg;

    assign cfg_fire      = cfg_valid && cfg_ready;
    assign busy          = start_reg || key_busy;
    assign cfg_ready     = !busy;
    assign advance       = !pipe[NS].valid || m_axis_tready;
    assign s_axis_tready = advance && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= aes_pkg::MODE_128;
            key_reg   <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_fire
                && (cfg_index inside {[aes_pkg::CFG_MODE:aes_pkg::CFG_KEY3]});
            if (cfg_fire)
            begin
                case (cfg_index)
                    aes_pkg::CFG_MODE: mode_reg   <= cfg_data[1:0];
                    aes_pkg::CFG_KEY0: key_reg[0] <= cfg_data;
                    aes_pkg::CFG_KEY1: key_reg[1] <= cfg_data;
                    aes_pkg::CFG_KEY2: key_reg[2] <= cfg_data;
                    aes_pkg::CFG_KEY3: key_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    aes_key_expand #(
        .RK_DEPTH   (RK_DEPTH)
    ) u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .mode       (mode_reg),
        .key_parts  (key_reg),
        .busy       (key_busy),
        .rk_out     (rkey)
    );

    assign in_state = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    always_comb
    begin
        case (mode_reg)
            aes_pkg::MODE_128: first_key = rkey[10];
            aes_pkg::MODE_192: first_key = rkey[12];
            default:           first_key = rkey[14];
        endcase
        if (!s_axis_tuser[0])
        begin
            first_key = rkey[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op0_reg <= s_axis_tuser[0];
            st0_reg <= in_state ^ first_key;
        end
    end

    assign pipe[0] = '{valid: v0_reg, op: op0_reg, state: st0_reg};

    for (genvar r = 1; r <= NS; r++)
    begin : g_round
        localparam int D10 = (r <= 10) ? 10 - r : 0;
        localparam int D12 = (r <= 12) ? 12 - r : 0;
        localparam int D14 = 14 - r;

        logic [aes_pkg::BLOCK_W-1:0] dec_key;

        assign dec_key = (mode_reg == aes_pkg::MODE_128) ? rkey[D10] :
                         (mode_reg == aes_pkg::MODE_192) ? rkey[D12] : rkey[D14];

        aes_round #(
            .STAGE (r)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .mode      (mode_reg),
            .enc_key   (rkey[r]),
            .dec_key   (dec_key),
            .stage_in  (pipe[r - 1]),
            .stage_out (pipe[r])
        );
    end

    assign m_axis_tvalid = pipe[NS].valid;
    assign m_axis_tdata  = {pipe[NS].state[63:0], pipe[NS].state[127:64]};

`include "assert_macros.svh"

    `AES_ASSERT_NEXT(a_cfg_starts_expand, clk, rst_n, cfg_fire && (cfg_index <= aes_pkg::CFG_KEY3), busy, "key write did not start expansion")
    `AES_ASSERT_IMPLIES(a_no_input_while_expand, clk, rst_n, key_busy || start_reg, !s_axis_tready, "input accepted during key expansion")
    `AES_ASSERT_NEXT(a_first_stage_moves, clk, rst_n, v0_reg && advance, pipe[1].valid, "block lost after first stage")
    `AES_ASSERT_NEXT(a_out_held, clk, rst_n, pipe[NS - 1].valid && !advance, pipe[NS - 1].valid, "stalled block dropped inside pipeline")

endmodule

// ===== rtl/aes_key_expand.sv =====
// Round key expansion: loads the key words, then derives one word per cycle.
// Depends on aes_pkg for the S-box, round counts and mode codes.
module aes_key_expand #(
    parameter int RK_DEPTH = aes_pkg::RK_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [1:0]                                mode,
    input  logic [3:0][63:0]                          key_parts,
    output logic                                      busy,
    output logic [aes_pkg::MAX_ROUNDS:0][aes_pkg::BLOCK_W-1:0] rk_out
);

    localparam int AW = $clog2(RK_DEPTH);
    localparam int CW = aes_pkg::RK_COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [2:0]      mod_reg;
    logic [7:0]      rc_reg;
    logic [31:0]     win_reg [8];
    logic [31:0]     rk_reg [RK_DEPTH];

    logic [3:0]      nr;
    logic [3:0]      nk;
    logic [CW-1:0]   last_idx;
    logic [31:0]     kw [8];
    logic [31:0]     tmp;
    logic [31:0]     oldest;
    logic [31:0]     new_word;
    logic            keep;

    assign nr       = aes_pkg::rounds_of_mode(mode);
    assign nk       = nr - 4'd6;
    assign last_idx = CW'({2'b00, nr + 4'd1} << 2) - CW'(1);
    assign keep     = cnt_reg < CW'(RK_DEPTH);
    assign busy     = state_reg != ST_IDLE;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            kw[j] = j[0] ? key_parts[j >> 1][31:0] : key_parts[j >> 1][63:32];
        end
    end

    always_comb
    begin
        tmp = win_reg[0];
        if (mod_reg == 3'd0)
        begin
            tmp = aes_pkg::subst_word({tmp[23:0], tmp[31:24]}) ^ {rc_reg, 24'h000000};
        end
        else if (nk == 4'd8 && mod_reg == 3'd4)
        begin
            tmp = aes_pkg::subst_word(tmp);
        end
        case (nk)
            4'd4:    oldest = win_reg[3];
            4'd6:    oldest = win_reg[5];
            default: oldest = win_reg[7];
        endcase
        new_word = oldest ^ tmp;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_RUN;
            ST_RUN:  if (cnt_reg == last_idx) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mod_reg   <= '0;
            rc_reg    <= aes_pkg::RCON_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                cnt_reg <= CW'(nk);
                mod_reg <= '0;
                rc_reg  <= aes_pkg::RCON_INIT;
            end
            else if (state_reg == ST_RUN)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                mod_reg <= (mod_reg == 3'(nk - 4'd1)) ? 3'd0 : mod_reg + 3'd1;
                if (mod_reg == 3'd0)
                begin
                    rc_reg <= aes_pkg::xt(rc_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin : store_upd
        int idx;
        if (state_reg == ST_LOAD)
        begin
            for (int k = 0; k < 8; k++)
            begin
                idx = int'(nk) - 1 - k;
                win_reg[k] <= (idx >= 0) ? kw[idx[2:0]] : 32'h0;
                if (k < int'(nk) && k < RK_DEPTH)
                begin
                    rk_reg[k] <= kw[k];
                end
            end
        end
        else if (state_reg == ST_RUN)
        begin
            win_reg[0] <= keep ? new_word : 32'h0;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
            if (keep)
            begin
                rk_reg[cnt_reg[AW-1:0]] <= new_word;
            end
        end
    end

    for (genvar k = 0; k <= aes_pkg::MAX_ROUNDS; k++)
    begin : g_rk
        for (genvar w = 0; w < 4; w++)
        begin : g_word
            if (4 * k + w < RK_DEPTH)
            begin : g_real
                assign rk_out[k][127 - 32 * w -: 32] = rk_reg[4 * k + w];
            end
            else
            begin : g_zero
                assign rk_out[k][127 - 32 * w -: 32] = 32'h0;
            end
        end
    end

endmodule

// ===== rtl/aes_round.sv =====
// One pipelined AES round, encrypt or decrypt, bypassed beyond the last round.
// Depends on aes_pkg for the round functions and the stage record.
module aes_round #(
    parameter int STAGE = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [1:0]                    mode,
    input  logic [aes_pkg::BLOCK_W-1:0]   enc_key,
    input  logic [aes_pkg::BLOCK_W-1:0]   dec_key,
    input  aes_pkg::stage_t               stage_in,
    output aes_pkg::stage_t               stage_out
);

    logic [3:0]                  nr;
    logic                        active;
    logic                        last_round;
    logic [aes_pkg::BLOCK_W-1:0] enc_state;
    logic [aes_pkg::BLOCK_W-1:0] dec_state;
    logic [aes_pkg::BLOCK_W-1:0] state_next;
    logic                        valid_reg;
    logic                        op_reg;
    logic [aes_pkg::BLOCK_W-1:0] state_reg;

    assign nr         = aes_pkg::rounds_of_mode(mode);
    assign active     = 4'(STAGE) <= nr;
    assign last_round = 4'(STAGE) == nr;

    always_comb
    begin
        enc_state = aes_pkg::rotate_state_rows(aes_pkg::subst_state(stage_in.state, 1'b0),
                                               1'b0);
        if (!last_round)
        begin
            enc_state = aes_pkg::mix_state(enc_state, 1'b0);
        end
        enc_state = enc_state ^ enc_key;

        dec_state = aes_pkg::subst_state(aes_pkg::rotate_state_rows(stage_in.state, 1'b1),
                                         1'b1) ^ dec_key;
        if (!last_round)
        begin
            dec_state = aes_pkg::mix_state(dec_state, 1'b1);
        end

        if (!active)
        begin
            state_next = stage_in.state;
        end
        else
        begin
            state_next = stage_in.op ? dec_state : enc_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg    <= stage_in.op;
            state_reg <= state_next;
        end
    end

    assign stage_out = '{valid: valid_reg, op: op_reg, state: state_reg};

endmodule
